// ----- rtl/i2cbs_pkg.sv -----
`default_nettype none

package i2cbs_pkg;

  // Width and reset value of the phase length register.
  localparam int unsigned PHASE_W          = 16;
  localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd720;

  // Default width of the phase timer.
  localparam int unsigned TIMER_W_DEFAULT  = 16;

  // Width of the phase index and of the sub-phase counter.
  localparam int unsigned IDX_W = 5;
  localparam int unsigned SUB_W = 2;

  // Number of bits in a data byte.
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_SEND_BYTE = 3'd3,
    CMD_RECV_ACK  = 3'd4,
    CMD_SEND_ACK  = 3'd5,
    CMD_RECV_BYTE = 3'd6,
    CMD_IGNORE    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_SCL  = 2'd0,
    ACT_SDA  = 2'd1,
    ACT_READ = 2'd2
  } act_e;

  // Action of one bus phase.
  typedef struct packed {
    act_e act;
    logic val;        // level driven on SCL or SDA
    logic shift_out;  // the driven SDA bit is shifted out of the byte register
  } phase_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_to_send;
    logic              sda_in;
  } in_item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_received;
  } out_item_t;

  // Number of phases of each command.
  function automatic logic [IDX_W-1:0] phase_count(cmd_e cmd);
    logic [IDX_W-1:0] cnt;
    unique case (cmd)
      CMD_START:     cnt = 5'd4;
      CMD_STOP:      cnt = 5'd3;
      CMD_SEND_BYTE: cnt = 5'd24;
      CMD_RECV_ACK:  cnt = 5'd4;
      CMD_SEND_ACK:  cnt = 5'd3;
      CMD_RECV_BYTE: cnt = 5'd25;
      default:       cnt = 5'd0;
    endcase
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/i2cbs_phase_dec.sv -----
`default_nettype none

// Decodes the bus action of one phase of a command.
module i2cbs_phase_dec
  import i2cbs_pkg::*;
(
  input  cmd_e             cmd_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [SUB_W-1:0] sub_i,
  input  logic             msb_i,
  output phase_t           phase_o
);

  always_comb begin
    phase_o = '{act: ACT_SCL, val: 1'b1, shift_out: 1'b0};
    unique case (cmd_i)
      CMD_START: begin
        phase_o.act = (idx_i == 5'd0 || idx_i == 5'd2) ? ACT_SDA : ACT_SCL;
        phase_o.val = (idx_i < 5'd2);
      end
      CMD_STOP: begin
        phase_o.act = (idx_i == 5'd1) ? ACT_SCL : ACT_SDA;
        phase_o.val = (idx_i != 5'd0);
      end
      CMD_SEND_BYTE, CMD_SEND_ACK: begin
        if (sub_i == 2'd0) begin
          phase_o.act       = ACT_SDA;
          phase_o.val       = msb_i;
          phase_o.shift_out = 1'b1;
        end else begin
          phase_o.act = ACT_SCL;
          phase_o.val = (sub_i == 2'd1);
        end
      end
      CMD_RECV_ACK: begin
        if (idx_i == 5'd0) begin
          phase_o.act = ACT_SDA;
          phase_o.val = 1'b1;
        end else if (idx_i == 5'd1) begin
          phase_o.act = ACT_SCL;
          phase_o.val = 1'b1;
        end else if (idx_i == 5'd2) begin
          phase_o.act = ACT_READ;
        end else begin
          phase_o.act = ACT_SCL;
          phase_o.val = 1'b0;
        end
      end
      CMD_RECV_BYTE: begin
        if (idx_i == 5'd0) begin
          phase_o.act = ACT_SDA;
          phase_o.val = 1'b1;
        end else if (sub_i == 2'd1) begin
          phase_o.act = ACT_READ;
        end else begin
          phase_o.act = ACT_SCL;
          phase_o.val = (sub_i == 2'd0);
        end
      end
      default: begin
        phase_o = '{act: ACT_SCL, val: 1'b1, shift_out: 1'b0};
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/i2cbs_seq.sv -----
`default_nettype none

// Sequencer state: command, phase position, phase timer, shift register and pin levels.
module i2cbs_seq
  import i2cbs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_W_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  in_item_t           item_i,
  input  logic [PHASE_W-1:0] phase_cycles_i,
  output out_item_t          result_o
);

  cmd_e                   cmd_q, cmd_d;
  logic [IDX_W-1:0]       idx_q, idx_d, idx_inc;
  logic [SUB_W-1:0]       sub_q, sub_d, sub_inc, sub_start;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d, timer_dec;
  logic [TIMER_WIDTH-1:0] load_sat, load_val;
  logic [BYTE_W-1:0]      shift_q, shift_d, shift_init;
  logic [BYTE_W-1:0]      rx_q, rx_d;
  logic                   scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic                   done;
  logic                   do_phase;
  logic                   busy;
  logic                   start_ok;
  cmd_e                   op;

  cmd_e                   dec_cmd;
  logic [IDX_W-1:0]       dec_idx;
  logic [SUB_W-1:0]       dec_sub;
  logic                   dec_msb;
  phase_t                 phase;

  // Phase length, saturated to the timer range and never zero.
  if (TIMER_WIDTH >= PHASE_W) begin : g_load_wide
    assign load_sat = TIMER_WIDTH'(phase_cycles_i);
  end else begin : g_load_narrow
    assign load_sat = (|phase_cycles_i[PHASE_W-1:TIMER_WIDTH]) ? '1
                                                                : phase_cycles_i[TIMER_WIDTH-1:0];
  end
  assign load_val = (load_sat == '0) ? TIMER_WIDTH'(1) : load_sat;

  assign op        = cmd_e'(item_i.opcode);
  assign busy      = (cmd_q != CMD_NONE);
  assign start_ok  = (op != CMD_NONE) && (op != CMD_IGNORE);
  assign idx_inc   = idx_q + 5'd1;
  assign sub_inc   = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
  assign sub_start = (op == CMD_RECV_BYTE) ? 2'd2 : 2'd0;
  assign timer_dec = (timer_q != '0) ? timer_q - TIMER_WIDTH'(1) : timer_q;

  always_comb begin
    unique case (op)
      CMD_SEND_BYTE: shift_init = item_i.tx_byte;
      CMD_SEND_ACK:  shift_init = {item_i.ack_to_send, 7'd0};
      default:       shift_init = '0;
    endcase
  end

  // The decoder sees either the next phase of the running command or the
  // first phase of a new one.
  always_comb begin
    if (busy) begin
      dec_cmd = cmd_q;
      dec_idx = idx_inc;
      dec_sub = sub_inc;
      dec_msb = shift_q[BYTE_W-1];
    end else begin
      dec_cmd = op;
      dec_idx = '0;
      dec_sub = sub_start;
      dec_msb = shift_init[BYTE_W-1];
    end
  end

  i2cbs_phase_dec u_phase_dec (
    .cmd_i   (dec_cmd),
    .idx_i   (dec_idx),
    .sub_i   (dec_sub),
    .msb_i   (dec_msb),
    .phase_o (phase)
  );

  always_comb begin
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    sub_d    = sub_q;
    timer_d  = timer_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    done     = 1'b0;
    do_phase = 1'b0;

    if (busy) begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        sub_d = sub_inc;
        if (idx_inc >= phase_count(cmd_q)) begin
          if (cmd_q == CMD_RECV_BYTE) begin
            rx_d = shift_q;
          end
          cmd_d = CMD_NONE;
          idx_d = '0;
          done  = 1'b1;
        end else begin
          idx_d    = idx_inc;
          do_phase = 1'b1;
        end
      end
    end else if (start_ok) begin
      cmd_d    = op;
      idx_d    = '0;
      sub_d    = sub_start;
      shift_d  = shift_init;
      do_phase = 1'b1;
    end

    if (do_phase) begin
      unique case (phase.act)
        ACT_SCL: scl_d = phase.val;
        ACT_SDA: begin
          sda_d = phase.val;
          if (phase.shift_out) begin
            shift_d = {shift_d[BYTE_W-2:0], 1'b0};
          end
        end
        ACT_READ: begin
          if (dec_cmd == CMD_RECV_ACK) begin
            ack_d = item_i.sda_in;
          end else begin
            shift_d = {shift_d[BYTE_W-2:0], item_i.sda_in};
          end
        end
        default: scl_d = scl_q;
      endcase
      timer_d = load_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_NONE;
      idx_q   <= '0;
      sub_q   <= '0;
      timer_q <= '0;
      shift_q <= '0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b1;
    end else if (step_i) begin
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
    end
  end

  assign result_o = '{scl_out:      scl_d,
                      sda_out:      sda_d,
                      busy_res:     (cmd_d != CMD_NONE),
                      done_res:     done,
                      rx_byte:      rx_d,
                      ack_received: ack_d};

endmodule

`default_nettype wire

// ----- rtl/i2c_master_bit_sequencer.sv -----
// The result word for an input word is registered and appears in the cycle after it is taken.
// Throughput: one word per cycle; every input word advances the bus sequencer by one step.
// While a result word is stalled the input is stalled too; a new word is taken in the same
// cycle in which the held result leaves.
// Reset (rst_ni low, asynchronous) idles the sequencer, releases SCL and SDA, sets the phase
// length register to 720, clears the received byte and sets the ack bit high.
`default_nettype none

module i2c_master_bit_sequencer
  import i2cbs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_W_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // Phase length register.
  input  logic               cfg_wr_en_i,
  input  logic [PHASE_W-1:0] cfg_wr_data_i,

  // Input words: one bus sequencer step each.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,

  // Result words: pin levels and status after each step.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic [PHASE_W-1:0] phase_cycles_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q;
  out_item_t          result;
  logic               in_accept;

  // The phase length may be rewritten at any time. A running command keeps
  // its current phase timer and picks up the new length at its next phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_cycles_q <= PHASE_RESET;
    end else if (cfg_wr_en_i) begin
      phase_cycles_q <= cfg_wr_data_i;
    end
  end

  // A new word is taken whenever the result register is empty or its word
  // leaves in this same cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // The sequencer advances exactly once per accepted word and presents the
  // state it moves to as that word's result.
  i2cbs_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_accept),
    .item_i         (in_data_i),
    .phase_cycles_i (phase_cycles_q),
    .result_o       (result)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- tb/i2c_master_bit_sequencer_test.sv -----
`default_nettype none

module i2c_master_bit_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbs_pkg::*;

  // The run ends as a failure if it is still going after this many cycles. The
  // slowest correct run, with every word hit by the longest sender gap and the
  // longest receiver stall, stays far below it.
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_wr_en_i;
  logic [PHASE_W-1:0] cfg_wr_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;

  i2c_master_bit_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  // Words waiting to be sent, and the pin and status words that the bus
  // sequencer should answer with, oldest first.
  in_item_t    step_q[$];
  out_item_t   pin_state_q[$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned idle_pct;   // chance in percent that either side starts an idle burst
  int unsigned gap_left;
  int unsigned stall_left;

  // Our own copy of the bus sequencer: the command in progress, where it is in
  // its phase list, the phase timer and the pin and status levels.
  cmd_e               bus_cmd;
  logic [IDX_W-1:0]   bus_phase;
  logic [15:0]        bus_timer;
  logic [BYTE_W-1:0]  bus_shift;
  logic               scl_lvl;
  logic               sda_lvl;
  logic               ack_lvl;
  logic [BYTE_W-1:0]  rx_last;
  logic [PHASE_W-1:0] phase_len;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Number of bus phases that a command walks through.
  function automatic int unsigned phases_of(cmd_e c);
    case (c)
      CMD_START, CMD_RECV_ACK:  return 4;
      CMD_STOP, CMD_SEND_ACK:   return 3;
      CMD_SEND_BYTE:            return 24;
      CMD_RECV_BYTE:            return 25;
      default:                  return 0;
    endcase
  endfunction

  // A phase length of zero is loaded as one. The timer is as wide as the
  // register, so no value has to be clipped.
  function automatic logic [15:0] phase_load();
    return (phase_len == '0) ? 16'd1 : phase_len;
  endfunction

  // Carries out the pin action of one phase of the active command and restarts
  // the phase timer.
  function automatic void run_phase(logic [IDX_W-1:0] idx, logic sda_in);
    int unsigned sub;
    sub = 0;
    case (bus_cmd)
      CMD_START: begin
        // Release SDA, raise SCL, pull SDA low while SCL is high, then SCL low.
        if (idx[0] == 1'b0) sda_lvl = (idx < 2);
        else scl_lvl = (idx < 2);
      end
      CMD_STOP: begin
        // SDA low, SCL high, then release SDA while SCL is high.
        if (idx == 1) scl_lvl = 1'b1;
        else sda_lvl = (idx != 0);
      end
      CMD_SEND_BYTE, CMD_SEND_ACK: begin
        // Each bit is three phases: data on SDA, clock high, clock low.
        sub = idx % 3;
        if (sub == 0) begin
          sda_lvl = bus_shift[BYTE_W-1];
          bus_shift = {bus_shift[BYTE_W-2:0], 1'b0};
        end else begin
          scl_lvl = (sub == 1);
        end
      end
      CMD_RECV_ACK: begin
        if (idx == 0) sda_lvl = 1'b1;
        else if (idx == 1) scl_lvl = 1'b1;
        else if (idx == 2) ack_lvl = sda_in;
        else scl_lvl = 1'b0;
      end
      CMD_RECV_BYTE: begin
        // SDA is released once, then each bit is clock high, sample, clock low.
        if (idx == 0) begin
          sda_lvl = 1'b1;
        end else begin
          sub = (idx - 1) % 3;
          if (sub == 1) bus_shift = {bus_shift[BYTE_W-2:0], sda_in};
          else scl_lvl = (sub == 0);
        end
      end
      default: return;
    endcase
    bus_timer = phase_load();
  endfunction

  // Advances the bus sequencer by one accepted word and returns the word that
  // the block should send back for it.
  function automatic out_item_t bus_step(in_item_t w);
    out_item_t r;
    logic      done;
    done = 1'b0;
    if (bus_cmd != CMD_NONE) begin
      // Any opcode is dropped while a command runs, even in its last cycle.
      if (bus_timer != 0) bus_timer = bus_timer - 16'd1;
      if (bus_timer == 0) begin
        bus_phase = bus_phase + 1'b1;
        if (bus_phase >= phases_of(bus_cmd)) begin
          if (bus_cmd == CMD_RECV_BYTE) rx_last = bus_shift;
          bus_cmd = CMD_NONE;
          bus_phase = '0;
          done = 1'b1;
        end else begin
          run_phase(bus_phase, w.sda_in);
        end
      end
    end else if (w.opcode != CMD_NONE && w.opcode != CMD_IGNORE) begin
      // A new command does its first phase in the cycle it is taken.
      bus_cmd = cmd_e'(w.opcode);
      bus_phase = '0;
      if (bus_cmd == CMD_SEND_BYTE) bus_shift = w.tx_byte;
      else if (bus_cmd == CMD_SEND_ACK) bus_shift = {w.ack_to_send, 7'd0};
      else bus_shift = '0;
      run_phase(bus_phase, w.sda_in);
    end
    r.scl_out      = scl_lvl;
    r.sda_out      = sda_lvl;
    r.busy_res     = (bus_cmd != CMD_NONE);
    r.done_res     = done;
    r.rx_byte      = rx_last;
    r.ack_received = ack_lvl;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Queues one word with the given opcode and random content elsewhere.
  function automatic void push_word(cmd_e op);
    in_item_t w;
    w.opcode      = op;
    w.tx_byte     = 8'($urandom_range(0, 255));
    w.ack_to_send = 1'($urandom_range(0, 1));
    w.sda_in      = 1'($urandom_range(0, 1));
    step_q.push_back(w);
  endfunction

  // Queues a command and just enough words behind it to carry it to its done
  // cycle. Those words carry random opcodes, which the block must drop; the
  // word of the done cycle always carries a real command.
  function automatic void queue_cmd(cmd_e op, logic [7:0] tx, logic ack);
    in_item_t    w;
    int unsigned len;
    len = phases_of(op) * phase_load();
    w.opcode      = op;
    w.tx_byte     = tx;
    w.ack_to_send = ack;
    w.sda_in      = 1'($urandom_range(0, 1));
    step_q.push_back(w);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len - 1) push_word(cmd_e'($urandom_range(CMD_START, CMD_RECV_BYTE)));
      else push_word(cmd_e'($urandom_range(0, 7)));
    end
  endfunction

  // One bus transfer: start, an address byte and its ack, a few data bytes
  // written or read, then stop. Now and then the stop is left out, or a stray
  // word with any opcode is thrown in and the stream realigns behind it.
  function automatic void queue_transfer();
    int unsigned nbytes;
    logic        reading;
    nbytes  = $urandom_range(1, 3);
    reading = 1'($urandom_range(0, 1));
    queue_cmd(CMD_START, 8'h00, 1'b0);
    queue_cmd(CMD_SEND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
    queue_cmd(CMD_RECV_ACK, 8'h00, 1'b0);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (reading) begin
        queue_cmd(CMD_RECV_BYTE, 8'h00, 1'b0);
        queue_cmd(CMD_SEND_ACK, 8'($urandom_range(0, 255)), (i == nbytes - 1));
      end else begin
        queue_cmd(CMD_SEND_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        queue_cmd(CMD_RECV_ACK, 8'h00, 1'b0);
      end
    end
    if ($urandom_range(0, 7) != 0) queue_cmd(CMD_STOP, 8'h00, 1'b0);
    if ($urandom_range(0, 5) == 0) begin
      push_word(cmd_e'($urandom_range(0, 7)));
      // The longest command may have started; wait it out with words that can
      // start nothing.
      for (int unsigned i = 0; i < 25 * phase_load(); i++) begin
        push_word($urandom_range(0, 1) ? CMD_NONE : CMD_IGNORE);
      end
    end
    for (int unsigned i = $urandom_range(0, 2); i > 0; i--) begin
      push_word($urandom_range(0, 1) ? CMD_NONE : CMD_IGNORE);
    end
  endfunction

  // Blocks until every queued word has been taken and every result has come.
  task automatic wait_drained();
    while (step_q.size() != 0 || in_valid_i || pin_state_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The phase length is only changed with no word in flight. A command may
  // still be running on the bus; the new length then applies from its next
  // phase on, in the block and here alike.
  task automatic set_phase_len(logic [PHASE_W-1:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    phase_len = v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned base;
    base = step_q.size();
    while (step_q.size() - base < n) queue_transfer();
  endtask

  // Sender side. A word is taken at an edge with valid high and stall low; the
  // prediction is made right there, from the word that was on the port.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pin_state_q.push_back(bus_step(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (step_q.size() != 0 && $urandom_range(1, 100) <= idle_pct) begin
          gap_left = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (step_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= step_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks every result word against the oldest prediction and
  // throws in stall bursts of its own.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pin_state_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          mismatches++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("scl_out", want.scl_out, out_data_o.scl_out);
          check_field("sda_out", want.sda_out, out_data_o.sda_out);
          check_field("busy_res", want.busy_res, out_data_o.busy_res);
          check_field("done_res", want.done_res, out_data_o.done_res);
          check_field("rx_byte", want.rx_byte, out_data_o.rx_byte);
          check_field("ack_received", want.ack_received, out_data_o.ack_received);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    gap_left      = 0;
    stall_left    = 0;
    idle_pct      = 15;
    bus_cmd       = CMD_NONE;
    bus_phase     = '0;
    bus_timer     = '0;
    bus_shift     = '0;
    scl_lvl       = 1'b1;
    sda_lvl       = 1'b1;
    ack_lvl       = 1'b1;
    rx_last       = '0;
    phase_len     = PHASE_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Right after reset: words that start nothing must keep the sequencer idle.
    queue_cmd(CMD_NONE, 8'h00, 1'b0);
    queue_cmd(CMD_IGNORE, 8'hFF, 1'b1);

    // A phase length of zero must act as a length of one. Every command at least once,
    // with all-ones and all-zeros bytes and both ack levels.
    set_phase_len(16'd0);
    queue_cmd(CMD_START, 8'h00, 1'b1);
    queue_cmd(CMD_SEND_BYTE, 8'hFF, 1'b0);
    queue_cmd(CMD_RECV_ACK, 8'h00, 1'b0);
    queue_cmd(CMD_SEND_BYTE, 8'h00, 1'b1);
    queue_cmd(CMD_RECV_ACK, 8'hFF, 1'b1);
    queue_cmd(CMD_RECV_BYTE, 8'h00, 1'b0);
    queue_cmd(CMD_SEND_ACK, 8'h00, 1'b0);
    queue_cmd(CMD_RECV_BYTE, 8'hFF, 1'b1);
    queue_cmd(CMD_SEND_ACK, 8'hFF, 1'b1);
    queue_cmd(CMD_STOP, 8'h00, 1'b0);
    queue_cmd(CMD_NONE, 8'h5A, 1'b0);
    queue_cmd(CMD_IGNORE, 8'hA5, 1'b1);

    // Random transfers over short phase lengths, one stretch without any
    // idling and one with heavy idling on both sides.
    set_phase_len(16'd1);
    queue_random(60);
    idle_pct = 0;
    set_phase_len(16'd2);
    queue_random(60);
    idle_pct = 35;
    set_phase_len(16'd1);
    queue_random(60);

    // Longest phase, with no idling: a start that stays in its first phase
    // until the end of the run while more commands are thrown at it.
    idle_pct = 0;
    set_phase_len(16'hFFFF);
    push_word(CMD_START);
    for (int unsigned i = 0; i < 100; i++) push_word(cmd_e'($urandom_range(0, 7)));

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
